### hdl/mono_framebuffer_glyph_blitter_unit_macros.svh
// Assertion helpers
`ifndef MONO_FRAMEBUFFER_GLYPH_BLITTER_UNIT_MACROS_SVH
`define MONO_FRAMEBUFFER_GLYPH_BLITTER_UNIT_MACROS_SVH
`define MFGB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MFGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hdl/mfgb_pkg.sv
package mfgb_pkg;
    localparam int SCREEN_W_DEF   = 200;
    localparam int SCREEN_H_DEF   = 200;
    localparam int FIRST_CODE_DEF = 32;
    localparam int LAST_CODE_DEF  = 90;
    localparam int GLYPH_W_DEF    = 5;
    localparam int GLYPH_H_DEF    = 7;

    localparam logic [2:0] MODE_CLEAR = 3'd0;
    localparam logic [2:0] MODE_FILL  = 3'd1;
    localparam logic [2:0] MODE_GLYPH = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_LOAD  = 3'd4;

    localparam logic [7:0] CODE_QMARK = 8'h3F;
    localparam logic [7:0] CODE_LA    = 8'h61;
    localparam logic [7:0] CODE_LZ    = 8'h7A;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [11:0] x_pos;
        logic signed [11:0] y_pos;
        logic [9:0]         rect_width;
        logic [9:0]         rect_height;
        logic               color;
        logic [7:0]         code;
        logic [4:0]         scale;
        logic [12:0]        byte_index;
        logic [8:0]         table_index;
        logic [7:0]         table_value;
    } t_cmd;
endpackage

### hdl/mono_framebuffer_glyph_blitter_unit.sv
// Sequencing: clear writes every framebuffer byte; fill walks the clipped rectangle
//   pixel by pixel; glyph fetches each font column and fills a square per set dot.
// Throughput: one command at a time in the back end (single framebuffer port);
//   a two-entry front queue accepts further commands meanwhile.
// Output: one result register; the back end starts the next command while it waits.
// Reset: synchronous active-low, clears queue and control; stores undefined.
module mono_framebuffer_glyph_blitter_unit import mfgb_pkg::*; #(
    parameter int SCREEN_W   = SCREEN_W_DEF,
    parameter int SCREEN_H   = SCREEN_H_DEF,
    parameter int FIRST_CODE = FIRST_CODE_DEF,
    parameter int LAST_CODE  = LAST_CODE_DEF,
    parameter int GLYPH_W    = GLYPH_W_DEF,
    parameter int GLYPH_H    = GLYPH_H_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_mode,
    input  logic signed [11:0] i_x_pos,
    input  logic signed [11:0] i_y_pos,
    input  logic [9:0]         i_rect_width,
    input  logic [9:0]         i_rect_height,
    input  logic               i_color,
    input  logic [7:0]         i_char_code,
    input  logic [4:0]         i_scale,
    input  logic [12:0]        i_byte_index,
    input  logic [8:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_read_data,
    output logic               o_read_valid
);
    t_cmd w_in, w_q;
    logic w_qv, w_take;

    // pack one item
    assign w_in = '{mode: i_mode, x_pos: i_x_pos, y_pos: i_y_pos,
        rect_width: i_rect_width, rect_height: i_rect_height, color: i_color,
        code: i_char_code, scale: i_scale, byte_index: i_byte_index,
        table_index: i_table_index, table_value: i_table_value};

    mfgb_front #(.FIRST_CODE(FIRST_CODE), .LAST_CODE(LAST_CODE)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_cmd(w_in),
        .o_valid(w_qv), .o_cmd(w_q), .i_take(w_take));

    mfgb_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H), .FIRST_CODE(FIRST_CODE),
        .LAST_CODE(LAST_CODE), .GLYPH_W(GLYPH_W), .GLYPH_H(GLYPH_H)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .i_cmd(w_q), .o_take(w_take),
        .o_empty(empty), .i_pop(pop), .o_read_data, .o_read_valid);
endmodule

### hdl/mfgb_front.sv
module mfgb_front import mfgb_pkg::*; #(
    parameter int FIRST_CODE = FIRST_CODE_DEF,
    parameter int LAST_CODE  = LAST_CODE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_take
);
    // two-entry queue; code folding happens on entry
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    t_cmd       r_q [2];
    t_cmd       w_cls;
    logic [7:0] w_code;
    logic       w_push, w_pop;

    always_comb begin
        w_code = i_cmd.code;
        if (w_code >= CODE_LA && w_code <= CODE_LZ) w_code = w_code - 8'd32;
        if ({1'b0, w_code} < 9'(FIRST_CODE) || {1'b0, w_code} > 9'(LAST_CODE))
            w_code = CODE_QMARK;
        w_cls = i_cmd;
        w_cls.code = w_code;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;
    assign n_cnt   = r_cnt + {1'b0, w_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_cls;
    end
endmodule

### hdl/mfgb_back.sv
`include "mono_framebuffer_glyph_blitter_unit_macros.svh"
module mfgb_back import mfgb_pkg::*; #(
    parameter int SCREEN_W   = SCREEN_W_DEF,
    parameter int SCREEN_H   = SCREEN_H_DEF,
    parameter int FIRST_CODE = FIRST_CODE_DEF,
    parameter int LAST_CODE  = LAST_CODE_DEF,
    parameter int GLYPH_W    = GLYPH_W_DEF,
    parameter int GLYPH_H    = GLYPH_H_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_take,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_read_data,
    output logic       o_read_valid
);
    localparam int ROW_BYTES  = (SCREEN_W + 7) / 8;
    localparam int FB_BYTES   = ROW_BYTES * SCREEN_H;
    localparam int FONT_BYTES = (LAST_CODE - FIRST_CODE + 1) * GLYPH_W;
    localparam int FAW = $clog2(FB_BYTES);
    localparam int TAW = $clog2(FONT_BYTES);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_RROW  = 4'd2;  // rectangle: start row
    localparam logic [3:0] ST_RPIX  = 4'd3;  // rectangle: read byte
    localparam logic [3:0] ST_RWR   = 4'd4;  // rectangle: modify/write
    localparam logic [3:0] ST_GCOL  = 4'd5;  // glyph: fetch column
    localparam logic [3:0] ST_GDOT  = 4'd6;  // glyph: test dot
    localparam logic [3:0] ST_RDWT  = 4'd7;  // read wait
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_GFW   = 4'd9;  // glyph: font data wait

    logic [7:0] r_fb [FB_BYTES];
    logic [7:0] r_font [FONT_BYTES];

    logic [3:0]  r_st;
    t_cmd        r_c;
    logic [FAW-1:0] r_clr;
    // rectangle walk, 13-bit signed clipped bounds
    logic signed [12:0] r_px, r_py, r_x0, r_x1, r_y1;
    logic        r_glyph;
    logic [3:0]  r_col, r_row;
    logic [7:0]  r_bits;
    logic [TAW-1:0] r_fbase;
    logic [FAW-1:0] r_addr;
    logic [FAW:0]   r_rowbase;
    logic [7:0]  r_mask;
    logic [7:0]  r_fb_q, r_font_q;
    logic        r_has;
    logic [7:0]  r_rdata;
    logic        r_rvalid;
    // result of the command in progress, moved to the output register at the end
    logic [7:0]  r_wdata;
    logic        r_wvalid;

    logic signed [12:0] w_rx, w_ry, w_rw, w_rh, w_ex, w_ey;
    logic [8:0]  w_cs, w_rs;
    logic        w_load;

    assign o_take  = i_valid && (r_st == ST_IDLE);
    assign o_empty = !r_has;
    assign o_read_data  = r_rdata;
    assign o_read_valid = r_rvalid;
    assign w_load  = (r_st == ST_OUT) && (!r_has || i_pop);

    // rectangle source: a command rectangle or one scaled glyph dot
    always_comb begin
        w_cs = 9'(r_col) * 9'(r_c.scale);
        w_rs = 9'(r_row) * 9'(r_c.scale);
        if (r_glyph) begin
            w_rx = 13'(r_c.x_pos) + 13'(w_cs);
            w_ry = 13'(r_c.y_pos) + 13'(w_rs);
            w_rw = 13'(r_c.scale);
            w_rh = 13'(r_c.scale);
        end else begin
            w_rx = 13'(r_c.x_pos);
            w_ry = 13'(r_c.y_pos);
            w_rw = 13'(r_c.rect_width);
            w_rh = 13'(r_c.rect_height);
        end
        w_ex = w_rx + w_rw;
        w_ey = w_ry + w_rh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_has    <= 1'b0;
        end else begin
            if (w_load) r_has <= 1'b1;
            else if (r_has && i_pop) r_has <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (o_take) begin
                    r_c      <= i_cmd;
                    r_wdata  <= '0;
                    r_wvalid <= 1'b0;
                    r_clr    <= '0;
                    r_glyph  <= 1'b0;
                    r_col    <= '0;
                    r_row    <= '0;
                    r_fbase  <= TAW'((int'(i_cmd.code) - FIRST_CODE) * GLYPH_W);
                    unique case (i_cmd.mode)
                        MODE_CLEAR: r_st <= ST_CLR;
                        MODE_FILL:  r_st <= ST_RROW;
                        MODE_GLYPH: r_st <= ST_GCOL;
                        MODE_READ:  r_st <= ST_RDWT;
                        default:    r_st <= ST_OUT;
                    endcase
                end
                ST_CLR: begin
                    if (r_clr == FAW'(FB_BYTES - 1)) r_st <= ST_OUT;
                    r_clr <= r_clr + 1'b1;
                end
                ST_RROW: begin
                    r_x0 <= (w_rx < 0) ? 13'sd0 : w_rx;
                    r_px <= (w_rx < 0) ? 13'sd0 : w_rx;
                    r_py <= (w_ry < 0) ? 13'sd0 : w_ry;
                    r_x1 <= (w_ex > 13'(SCREEN_W)) ? 13'(SCREEN_W) : w_ex;
                    r_y1 <= (w_ey > 13'(SCREEN_H)) ? 13'(SCREEN_H) : w_ey;
                    r_rowbase <= (FAW+1)'((w_ry < 0 ? 0 : int'(w_ry)) * ROW_BYTES);
                    r_st <= ST_RPIX;
                end
                ST_RPIX: begin
                    if (r_py >= r_y1 || r_x0 >= r_x1) begin
                        r_st <= r_glyph ? ST_GDOT : ST_OUT;
                        if (r_glyph) r_row <= r_row + 1'b1;
                    end else if (r_px >= r_x1) begin
                        r_py <= r_py + 1'b1;
                        r_px <= r_x0;
                        r_rowbase <= r_rowbase + (FAW+1)'(ROW_BYTES);
                    end else begin
                        r_addr <= FAW'(r_rowbase + (FAW+1)'(r_px[12:3]));
                        r_mask <= 8'h80 >> r_px[2:0];
                        r_st <= ST_RWR;
                    end
                end
                ST_RWR: begin
                    r_px <= r_px + 1'b1;
                    r_st <= ST_RPIX;
                end
                ST_GCOL: begin
                    if (int'(r_col) >= GLYPH_W) r_st <= ST_OUT;
                    else r_st <= ST_GFW;
                    r_row <= '0;
                end
                ST_GFW: begin
                    r_bits <= r_font_q;
                    r_st <= ST_GDOT;
                end
                ST_GDOT: begin
                    if (int'(r_row) >= GLYPH_H) begin
                        r_col <= r_col + 1'b1;
                        r_fbase <= r_fbase + 1'b1;
                        r_st <= ST_GCOL;
                    end else if (r_bits[r_row[2:0]]) begin
                        r_glyph <= 1'b1;
                        r_st <= ST_RROW;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                ST_RDWT: begin
                    if (int'(r_c.byte_index) < FB_BYTES) begin
                        r_wdata  <= r_fb_q;
                        r_wvalid <= 1'b1;
                    end
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    // wait here while the previous result is still unread
                    if (w_load) begin
                        r_rdata  <= r_wdata;
                        r_rvalid <= r_wvalid;
                        r_st     <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // framebuffer port: at most one write and one read per cycle
    always_ff @(posedge i_clk) begin
        if (r_st == ST_CLR) begin
            r_fb[r_clr] <= {8{r_c.color}};
        end else if (r_st == ST_RWR) begin
            r_fb[r_addr] <= r_c.color ? (r_fb_q | r_mask) : (r_fb_q & ~r_mask);
        end
        if (r_st == ST_RPIX) r_fb_q <= r_fb[FAW'(r_rowbase + (FAW+1)'(r_px[12:3]))];
        else if (r_st == ST_IDLE) r_fb_q <= r_fb[i_cmd.byte_index[FAW-1:0]];
        else r_fb_q <= r_fb[r_c.byte_index[FAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && o_take && i_cmd.mode == MODE_LOAD
            && int'(i_cmd.table_index) < FONT_BYTES)
            r_font[i_cmd.table_index[TAW-1:0]] <= i_cmd.table_value;
        r_font_q <= r_font[r_fbase];
    end

    `MFGB_ASSERT_IMPL(a_take_idle, i_clk, i_rst_n, o_take, r_st == ST_IDLE, "take outside idle")
    `MFGB_ASSERT_NEXT(a_out_sets, i_clk, i_rst_n, r_st == ST_OUT, !o_empty, "result lost")
    `MFGB_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, !o_empty && !i_pop,
        !o_empty && $stable(o_read_data) && $stable(o_read_valid), "result changed while waiting")
endmodule
